// ===== sv/frx_pkg.sv =====
// ----------------------------------------------------------------------------
// frx_pkg: shared types and constants of the STX/ETX frame receiver
// Framing byte codes, status codes and the result word layout.
// ----------------------------------------------------------------------------
package frx_pkg;

  // framing byte codes
  localparam logic [7:0] STX_CODE  = 8'h02;
  localparam logic [7:0] ESC_CODE  = 8'h01;
  localparam logic [7:0] ETX_CODE  = 8'h03;
  localparam logic [7:0] ESC_MASK  = 8'h40;
  localparam logic [7:0] PLUS_CODE = 8'h2B;

  // configuration register
  localparam int          MAXP_W        = 10;
  localparam logic [9:0]  MAXP_RESET    = 10'd511;
  localparam logic [9:0]  MAXP_FLOOR    = 10'd2;
  localparam int          CFG_ADDR_W    = 3;
  localparam int          CFG_DATA_W    = 32;

  // result field widths
  localparam int POS_W = 9;
  localparam int LEN_W = 9;

  // result kind
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ST_ACK      = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_NACK     = 2'd2,
    ST_TOO_LONG = 2'd3
  } frx_status_t;

  // one result word
  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [POS_W-1:0]  position;
    frx_status_t       status;
    logic [LEN_W-1:0]  payload_length;
  } frx_res_t;

endpackage

// ===== sv/frx_cfg.sv =====
// ----------------------------------------------------------------------------
// frx_cfg: configuration register file
// APB-style slave holding max_payload; zero wait states.
// ----------------------------------------------------------------------------
module frx_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [frx_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [frx_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [frx_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready,
  output logic [frx_pkg::MAXP_W-1:0]     max_payload
);
  import frx_pkg::*;

  logic [MAXP_W-1:0] max_payload_r;
  logic              reg0_sel;
  logic              wr_en;

  // register 0 sits at byte address 0; low address bits are ignored
  assign reg0_sel   = (cfg_paddr[CFG_ADDR_W-1] == 1'b0);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg0_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAXP_RESET;
    end else if (wr_en) begin
      max_payload_r <= cfg_pwdata[MAXP_W-1:0];
    end
  end

  // read back
  assign cfg_prdata  = reg0_sel ? {{(CFG_DATA_W-MAXP_W){1'b0}}, max_payload_r}
                                : '0;
  assign max_payload = max_payload_r;

endmodule

// ===== sv/frx_core.sv =====
// ----------------------------------------------------------------------------
// frx_core: frame state and per-byte decision logic
// Holds the frame state, decodes one byte per step and forms its result.
// ----------------------------------------------------------------------------
module frx_core #(
  parameter int FRAME_BUFFER_BYTES = 512
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                rx_byte,
  input  logic [frx_pkg::MAXP_W-1:0] max_payload,
  output logic                      res_valid,
  output frx_pkg::frx_res_t         res
);
  import frx_pkg::*;

  localparam int CNT_W = $clog2(FRAME_BUFFER_BYTES + 1);
  localparam int LW    = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;
  localparam logic [LW-1:0] BUF_MAX = LW'(FRAME_BUFFER_BYTES);

  // frame state
  logic             in_frame_r,  in_frame_nxt;
  logic             esc_r,       esc_nxt;
  logic [7:0]       xor_r,       xor_nxt;
  logic [CNT_W-1:0] cnt_r,       cnt_nxt;
  logic             held_v_r,    held_v_nxt;
  logic [7:0]       held_byte_r, held_byte_nxt;
  logic [7:0]       first_byte_r, first_byte_nxt;

  logic [LW-1:0]    mp_ext;
  logic [LW-1:0]    lim;
  logic [LW-1:0]    cnt_ext;
  logic [LW-1:0]    cnt_m1;
  logic [LEN_W-1:0] len;
  logic [7:0]       dbyte;

  // effective limit: max_payload clamped to 2..buffer size
  assign mp_ext  = LW'(max_payload);
  assign lim     = (mp_ext < LW'(MAXP_FLOOR)) ? LW'(MAXP_FLOOR) :
                   (mp_ext > BUF_MAX)         ? BUF_MAX : mp_ext;
  assign cnt_ext = LW'(cnt_r);
  assign cnt_m1  = cnt_ext - LW'(1);
  assign len     = (cnt_r != '0) ? cnt_m1[LEN_W-1:0] : '0;
  assign dbyte   = esc_r ? (rx_byte & ~ESC_MASK) : rx_byte;

  // next state and result for the byte at hand
  always_comb begin
    in_frame_nxt   = in_frame_r;
    esc_nxt        = esc_r;
    xor_nxt        = xor_r;
    cnt_nxt        = cnt_r;
    held_v_nxt     = held_v_r;
    held_byte_nxt  = held_byte_r;
    first_byte_nxt = first_byte_r;
    res_valid      = 1'b0;
    res            = '0;
    priority if (rx_byte == STX_CODE) begin
      in_frame_nxt = 1'b1;
      esc_nxt      = 1'b0;
      xor_nxt      = '0;
      cnt_nxt      = '0;
      held_v_nxt   = 1'b0;
    end else if (!in_frame_r) begin
      // noise between frames
    end else if (rx_byte == ESC_CODE) begin
      esc_nxt = 1'b1;
    end else if (rx_byte == ETX_CODE) begin
      in_frame_nxt       = 1'b0;
      held_v_nxt         = 1'b0;
      res_valid          = 1'b1;
      res.kind           = KIND_REPORT;
      res.payload_length = len;
      priority if (xor_r != '0) begin
        res.status = ST_NACK;
      end else if (cnt_r != '0 && first_byte_r == PLUS_CODE) begin
        res.status = ST_IGNORED;
      end else begin
        res.status = ST_ACK;
      end
    end else if (cnt_ext >= lim) begin
      in_frame_nxt       = 1'b0;
      held_v_nxt         = 1'b0;
      res_valid          = 1'b1;
      res.kind           = KIND_REPORT;
      res.status         = ST_TOO_LONG;
      res.payload_length = len;
    end else begin
      // data byte: release the held one, hold this one
      esc_nxt       = 1'b0;
      xor_nxt       = xor_r ^ dbyte;
      res_valid     = held_v_r;
      res.kind      = KIND_DATA;
      res.data_byte = held_byte_r;
      res.position  = cnt_m1[POS_W-1:0];
      if (cnt_r == '0) begin
        first_byte_nxt = dbyte;
      end
      held_byte_nxt = dbyte;
      held_v_nxt    = 1'b1;
      cnt_nxt       = cnt_r + CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      xor_r      <= '0;
      cnt_r      <= '0;
      held_v_r   <= 1'b0;
    end else if (step) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      xor_r      <= xor_nxt;
      cnt_r      <= cnt_nxt;
      held_v_r   <= held_v_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (step) begin
      held_byte_r  <= held_byte_nxt;
      first_byte_r <= first_byte_nxt;
    end
  end

`ifndef SYNTHESIS
  // a start byte always opens an empty frame
  a_stx_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && rx_byte == STX_CODE) |=> (in_frame_r && cnt_r == '0 && !held_v_r))
    else $error("frx_core: start byte did not open an empty frame");

  // a held byte implies at least one stored byte
  a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> (cnt_r != '0))
    else $error("frx_core: held byte with zero count");

  // an end report closes the frame
  a_report_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res.kind == KIND_REPORT) |=> (!in_frame_r && !held_v_r))
    else $error("frx_core: frame still open after report");

  // count never passes the buffer size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= BUF_MAX)
    else $error("frx_core: stored count beyond buffer");
`endif

endmodule

// ===== sv/stx_etx_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver: STX/ETX framed byte receiver with XOR checksum
// Unescapes and checks framed bytes, releases payload bytes one byte late
// and reports each frame's status at its end.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data                          | tuser
//  --------+-----+---------------------------------------+-----------
//  in_     | in  | [7:0] rx_byte                         | -
//  out_    | out | [7:0] data_byte [16:8] position       | [0] kind
//          |     | [18:17] status [27:19] payload_length |
//  cfg_    | in  | 0x0 max_payload [9:0]                 | -
//
//  One word per cycle while out_tready stays high; each input word passes
//  an input register, then the frame decode into the output register.
//  rst_n is synchronous; it closes any frame and sets max_payload to 511.
//  in_tready drops only while both the input and output registers hold
//  words and out_tready is low.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver #(
  parameter int FRAME_BUFFER_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // data_byte, position,
                                                    // status, payload_length
  output logic                          out_tuser,  // [0] kind
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [frx_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [frx_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [frx_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import frx_pkg::*;

  logic [MAXP_W-1:0] max_payload;
  logic              in_v_r;
  logic [7:0]        in_byte_r;
  logic              out_v_r;
  frx_res_t          out_res_r;
  logic              s2_ready;
  logic              step;
  logic              res_valid;
  frx_res_t          res;

  frx_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_payload (max_payload)
  );

  // handshake through the two register stages
  assign s2_ready  = !out_v_r || out_tready;
  assign in_tready = !in_v_r || s2_ready;
  assign step      = in_v_r && s2_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  frx_core #(
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (in_byte_r),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_ready) begin
      out_v_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {4'b0, out_res_r.payload_length, out_res_r.status,
                       out_res_r.position, out_res_r.data_byte};

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the STX/ETX frame receiver
// Feeds framed, escaped and malformed byte streams through the input stream,
// predicts every released payload word and end-of-frame report, and checks
// them field by field against the result stream under several max_payload
// settings and back-pressure mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import frx_pkg::*;

  localparam int BUF_BYTES = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // [7:0] rx_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;      // [7:0] data_byte [16:8] position
                                         // [18:17] status [27:19] payload_length
  logic                  out_tuser;      // [0] kind
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  stx_etx_frame_receiver #(.FRAME_BUFFER_BYTES(BUF_BYTES)) dut (.*);

  // bytes waiting for the line, results waiting for the output
  logic [7:0]  rx_line[$];
  frx_res_t    frame_results[$];
  int unsigned pushed = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // receiver state as predicted
  logic [9:0]  max_pl = MAXP_RESET;
  logic        in_frm = 1'b0;
  logic        esc_pend = 1'b0;
  logic [7:0]  xsum = '0;
  int unsigned stored = 0;
  logic        held_ok = 1'b0;
  logic [7:0]  held = '0;
  logic [7:0]  lead = '0;
  frx_res_t    want;

  initial forever #5 clk = ~clk;

  // predict the results caused by one accepted line byte
  task automatic decode_rx(input logic [7:0] b);
    frx_res_t r;
    int unsigned lim;
    logic [7:0] d;
    r = '0;
    lim = (max_pl < MAXP_FLOOR) ? MAXP_FLOOR : ((max_pl > BUF_BYTES) ? BUF_BYTES : max_pl);
    if (b == STX_CODE) begin
      in_frm = 1'b1;
      esc_pend = 1'b0;
      xsum = '0;
      stored = 0;
      held_ok = 1'b0;
    end else if (in_frm) begin
      if (b == ESC_CODE) begin
        esc_pend = 1'b1;
      end else if (b == ETX_CODE || stored >= lim) begin
        // frame end or overflow: report and leave the frame
        in_frm = 1'b0;
        held_ok = 1'b0;
        r.kind = KIND_REPORT;
        r.payload_length = LEN_W'((stored > 0) ? stored - 1 : 0);
        if (b != ETX_CODE) r.status = ST_TOO_LONG;
        else if (xsum != 0) r.status = ST_NACK;
        else if (stored != 0 && lead == PLUS_CODE) r.status = ST_IGNORED;
        else r.status = ST_ACK;
        frame_results.push_back(r);
      end else begin
        d = esc_pend ? (b & ~ESC_MASK) : b;
        esc_pend = 1'b0;
        xsum ^= d;
        // the previous byte goes out one byte late
        if (held_ok) begin
          r.kind = KIND_DATA;
          r.data_byte = held;
          r.position = POS_W'(stored - 1);
          frame_results.push_back(r);
        end
        if (stored == 0) lead = d;
        held = d;
        held_ok = 1'b1;
        stored++;
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) decode_rx(in_tdata);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (rx_line.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= rx_line.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v, got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_results.size() == 0) begin
          $display("%0t: unexpected result word: expected none, actual %h/%b",
                   $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = frame_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_tuser));
          check_field("data_byte", 32'(want.data_byte), 32'(out_tdata[7:0]));
          check_field("position", 32'(want.position), 32'(out_tdata[16:8]));
          check_field("status", 32'(want.status), 32'(out_tdata[18:17]));
          check_field("payload_length", 32'(want.payload_length),
                      32'(out_tdata[27:19]));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_raw(input logic [7:0] b);
    rx_line.push_back(b);
    pushed++;
  endtask

  // send one decoded data byte, escaping it where needed or by chance
  task automatic push_data(input logic [7:0] d, input int unsigned esc_pct);
    if (d == STX_CODE || d == ESC_CODE || d == ETX_CODE ||
        (!d[6] && $urandom_range(99) < esc_pct)) begin
      push_raw(ESC_CODE);
      if ($urandom_range(9) == 0) push_raw(ESC_CODE);
      push_raw(d | ESC_MASK);
    end else begin
      push_raw(d);
    end
  endtask

  // a whole frame of n stored bytes, the last one being the checksum
  task automatic queue_frame(input int n, input bit sum_ok, input bit plus_lead,
                             input int unsigned esc_pct);
    logic [7:0] sum;
    logic [7:0] d;
    sum = '0;
    push_raw(STX_CODE);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) d = sum_ok ? sum : sum ^ 8'($urandom_range(1, 255));
      else if (i == 0 && plus_lead) d = PLUS_CODE;
      else d = 8'($urandom_range(255));
      sum ^= d;
      push_data(d, esc_pct);
    end
    push_raw(ETX_CODE);
  endtask

  // mostly well-formed frames, plus noise, garbage frames and cut-off frames
  task automatic random_traffic(input int unsigned n, input int unsigned max_len);
    int unsigned start;
    int unsigned r;
    start = pushed;
    while (pushed - start < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) push_raw(8'($urandom_range(255)));
      end else if (r < 16) begin
        push_raw(STX_CODE);
        repeat ($urandom_range(max_len)) push_raw(8'($urandom_range(255)));
        push_raw(ETX_CODE);
      end else if (r < 22) begin
        push_raw(STX_CODE);
        repeat ($urandom_range(max_len)) push_data(8'($urandom_range(255)), 20);
      end else begin
        queue_frame($urandom_range(max_len + 1), $urandom_range(99) < 85,
                    $urandom_range(99) < 15, 20);
      end
    end
  endtask

  // wait until every byte is taken and every result has come out
  task automatic drain();
    int unsigned waited;
    waited = 0;
    do @(negedge clk); while (rx_line.size() != 0 || in_tvalid);
    while (frame_results.size() != 0 && waited < 4000) begin
      @(negedge clk);
      waited++;
    end
    if (frame_results.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0",
               $time, frame_results.size());
      errors++;
      frame_results.delete();
    end
    // frame bytes with no result may still be in flight
    repeat (8) @(negedge clk);
  endtask

  task automatic write_max(input logic [9:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= REG_MAX_PAYLOAD;
    cfg_pwdata <= CFG_DATA_W'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    max_pl = v;
  endtask

  task automatic set_idle(input int unsigned send_pct, recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    logic [7:0] opening[$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray bytes, empty, '+' frame, extremes, nack, restart, escapes
    set_idle(0, 0);
    opening = '{8'hFF, ETX_CODE,
                STX_CODE, ETX_CODE,
                STX_CODE, PLUS_CODE, PLUS_CODE, ETX_CODE,
                STX_CODE, 8'h80, 8'h7F, 8'hFF, ETX_CODE,
                STX_CODE, 8'h10, 8'h11, ETX_CODE,
                STX_CODE, 8'h55, STX_CODE, ESC_CODE, ESC_CODE, 8'h42, ESC_CODE, 8'h42,
                ETX_CODE};
    foreach (opening[i]) push_raw(opening[i]);
    drain();

    // smallest limit, overflow on the third data byte
    write_max(10'd2);
    set_idle(67, 0);
    opening = '{STX_CODE, 8'h11, 8'h22, 8'h33, ETX_CODE};
    foreach (opening[i]) push_raw(opening[i]);
    random_traffic(20, 4);
    drain();

    // limits below the floor clamp to two
    write_max(10'd0);
    set_idle(0, 67);
    random_traffic(20, 4);
    drain();

    write_max(10'd1);
    set_idle(7, 7);
    random_traffic(15, 3);
    drain();

    // largest limit: one frame overruns the full buffer
    write_max(10'h3FF);
    set_idle(0, 0);
    push_raw(STX_CODE);
    repeat (BUF_BYTES + 1) push_data(8'($urandom_range(255)), 10);
    push_raw(ETX_CODE);
    drain();

    write_max(10'd512);
    set_idle(67, 0);
    random_traffic(25, 16);
    drain();

    write_max(10'd3);
    set_idle(0, 67);
    random_traffic(20, 6);
    drain();

    write_max(10'($urandom_range(4, 40)));
    set_idle(7, 7);
    random_traffic(40, 40);
    drain();

    write_max(10'd511);
    set_idle(0, 0);
    random_traffic(20, 20);
    drain();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/frx_pkg.sv
sv/frx_cfg.sv
sv/frx_core.sv
sv/stx_etx_frame_receiver.sv
tb/testbench.sv
